// File: design/msp_pkg.sv
// ============================================================================
// Mesh stencil pattern package
// Widths, register indexes, result step codes and the queue entry type shared
// by the stencil pattern generator.
// ============================================================================
`default_nettype none

package msp_pkg;

	localparam int POS_W       = 6;
	localparam int SIZE_W      = 7;
	localparam int IDX_W       = 18;
	localparam int SXY_W       = 14;
	localparam int PY_W        = 13;
	localparam int PZ_W        = 20;
	localparam int NSTEP       = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;
	localparam int DEF_MAX_DIM = 64;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SIZE_W-1:0] DEF_SIZE  = 7'd64;
	localparam logic              DEF_TETRA = 1'b0;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TETRA  = 2'd3;

	typedef enum logic [3:0] {
		STEP_DIAG  = 4'd0,
		STEP_XN_A  = 4'd1,
		STEP_XN_B  = 4'd2,
		STEP_YN_A  = 4'd3,
		STEP_YN_B  = 4'd4,
		STEP_ZN_A  = 4'd5,
		STEP_ZN_B  = 4'd6,
		STEP_XY_A  = 4'd7,
		STEP_XY_B  = 4'd8,
		STEP_XZ_A  = 4'd9,
		STEP_XZ_B  = 4'd10,
		STEP_YZ_A  = 4'd11,
		STEP_YZ_B  = 4'd12
	} step_t;

	typedef struct packed {
		logic [IDX_W-1:0] p;
		logic [SIZE_W-1:0] sx;
		logic [SXY_W-1:0] sxy;
		logic [NSTEP-1:0] mask;
		logic even;
		logic inv;
	} entry_t;

endpackage

`default_nettype wire

// File: design/msp_ifs.sv
// ============================================================================
// Mesh stencil pattern channels
// Valid/ready channels for grid points in and matrix entries out.
// ============================================================================
`default_nettype none

interface msp_point_if;
	import msp_pkg::*;

	logic valid;
	logic ready;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic [POS_W-1:0] pos_z;

	modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface msp_entry_if;
	import msp_pkg::*;

	logic valid;
	logic ready;
	logic [IDX_W-1:0] row_index;
	logic [IDX_W-1:0] col_index;
	logic last_entry;
	logic point_invalid;

	modport source (output valid, output row_index, output col_index,
		output last_entry, output point_invalid, input ready);
	modport sink (input valid, input row_index, input col_index,
		input last_entry, input point_invalid, output ready);
endinterface

`default_nettype wire

// File: design/msp_front.sv
// ============================================================================
// Mesh stencil pattern front end
// Holds the configuration, accepts grid points, checks bounds and builds the
// linear index and the set of entries each point produces.
// ============================================================================
`default_nettype none

module msp_front #(
	parameter int MAX_DIM = msp_pkg::DEF_MAX_DIM
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [msp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [msp_pkg::CFG_DATA_W-1:0] cfg_data,
	msp_point_if.sink pt,
	output msp_pkg::entry_t q_data,
	output logic q_valid,
	input  logic q_ready
);
	import msp_pkg::*;

	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] s);
		return (32'(s) > MAX_DIM) ? SIZE_W'(MAX_DIM) : s;
	endfunction

	logic [SIZE_W-1:0] size_x_q;
	logic [SIZE_W-1:0] size_y_q;
	logic [SIZE_W-1:0] size_z_q;
	logic tetra_q;
	logic [SXY_W-1:0] sxy_q;

	logic [SIZE_W-1:0] eff_x;
	logic [SIZE_W-1:0] eff_y;
	logic [SIZE_W-1:0] eff_z;

	logic v_s1;
	logic [POS_W-1:0] x_s1;
	logic [POS_W-1:0] y_s1;
	logic [POS_W-1:0] z_s1;

	logic v_s2;
	logic [POS_W-1:0] x_s2;
	logic [PY_W-1:0] py_s2;
	logic [IDX_W-1:0] pz_s2;
	logic [SIZE_W-1:0] sx_s2;
	logic [SXY_W-1:0] sxy_s2;
	logic [NSTEP-1:0] mask_s2;
	logic even_s2;
	logic inv_s2;

	logic s1_free;
	logic s2_free;
	logic inv;
	logic has_x;
	logic has_y;
	logic has_z;
	logic f_xy;
	logic f_xz;
	logic f_yz;
	logic [SIZE_W-1:0] xp1;
	logic [SIZE_W-1:0] yp1;
	logic [SIZE_W-1:0] zp1;
	logic [NSTEP-1:0] mask;
	logic [PZ_W-1:0] pz_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= DEF_SIZE;
			size_y_q <= DEF_SIZE;
			size_z_q <= DEF_SIZE;
			tetra_q  <= DEF_TETRA;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_SIZE_Z: size_z_q <= cfg_data;
				REG_TETRA:  tetra_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign eff_x = sat_size(size_x_q);
	assign eff_y = sat_size(size_y_q);
	assign eff_z = sat_size(size_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sxy_q <= '0;
		end else begin
			sxy_q <= SXY_W'(eff_x) * SXY_W'(eff_y);
		end
	end

	assign s2_free  = !v_s2 || q_ready;
	assign s1_free  = !v_s1 || s2_free;
	assign pt.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= pt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pt.valid && s1_free) begin
			x_s1 <= pt.pos_x;
			y_s1 <= pt.pos_y;
			z_s1 <= pt.pos_z;
		end
	end

	always_comb begin
		inv   = (SIZE_W'(x_s1) >= eff_x) || (SIZE_W'(y_s1) >= eff_y) ||
			(SIZE_W'(z_s1) >= eff_z);
		xp1   = SIZE_W'(x_s1) + SIZE_W'(1);
		yp1   = SIZE_W'(y_s1) + SIZE_W'(1);
		zp1   = SIZE_W'(z_s1) + SIZE_W'(1);
		has_x = x_s1 != '0;
		has_y = y_s1 != '0;
		has_z = z_s1 != '0;
		f_xy  = tetra_q && (xp1 < eff_x) && (yp1 < eff_y);
		f_xz  = tetra_q && (xp1 < eff_x) && (zp1 < eff_z);
		f_yz  = tetra_q && (yp1 < eff_y) && (zp1 < eff_z);
		if (inv) begin
			mask = NSTEP'(1);
		end else begin
			mask = {f_yz, f_yz, f_xz, f_xz, f_xy, f_xy,
				has_z, has_z, has_y, has_y, has_x, has_x, 1'b1};
		end
		pz_full = PZ_W'(sxy_q) * PZ_W'(z_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && s2_free) begin
			x_s2    <= x_s1;
			py_s2   <= PY_W'(eff_x) * PY_W'(y_s1);
			pz_s2   <= pz_full[IDX_W-1:0];
			sx_s2   <= eff_x;
			sxy_s2  <= sxy_q;
			mask_s2 <= mask;
			even_s2 <= ~(x_s1[0] ^ y_s1[0] ^ z_s1[0]);
			inv_s2  <= inv;
		end
	end

	always_comb begin
		q_data.p    = IDX_W'(x_s2) + IDX_W'(py_s2) + pz_s2;
		q_data.sx   = sx_s2;
		q_data.sxy  = sxy_s2;
		q_data.mask = mask_s2;
		q_data.even = even_s2;
		q_data.inv  = inv_s2;
	end

	assign q_valid = v_s2;

endmodule

`default_nettype wire

// File: design/msp_queue.sv
// ============================================================================
// Mesh stencil pattern queue
// Short first-in first-out queue of classified points between the front end
// and the entry sequencer.
// ============================================================================
`default_nettype none

module msp_queue (
	input  logic clk,
	input  logic arst_n,
	input  msp_pkg::entry_t push_data,
	input  logic push_valid,
	output logic push_ready,
	output msp_pkg::entry_t pop_data,
	output logic pop_valid,
	input  logic pop_ready
);
	import msp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/msp_back.sv
// ============================================================================
// Mesh stencil pattern entry sequencer
// Walks the entry set of one point and produces one matrix coordinate pair per
// cycle into the output register, unless the output is held by back-pressure.
// ============================================================================
`default_nettype none

module msp_back (
	input  logic clk,
	input  logic arst_n,
	input  msp_pkg::entry_t q_data,
	input  logic q_valid,
	output logic q_ready,
	msp_entry_if.source ent
);
	import msp_pkg::*;

	entry_t cur_q;
	logic busy_q;
	logic [NSTEP-1:0] rem_q;

	logic ov_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic last_q;
	logic inv_q;

	logic emit;
	logic last;
	logic take;
	logic [NSTEP-1:0] rem_nx;
	step_t step;
	logic [IDX_W-1:0] sx_w;
	logic [IDX_W-1:0] sxy_w;
	logic [IDX_W-1:0] off_r;
	logic [IDX_W-1:0] off_c;
	logic [IDX_W-1:0] diag_a;
	logic [IDX_W-1:0] diag_b;

	assign emit    = busy_q && (!ov_q || ent.ready);
	assign rem_nx  = rem_q & (rem_q - NSTEP'(1));
	assign last    = rem_nx == '0;
	assign q_ready = !busy_q || (emit && last);
	assign take    = q_valid && q_ready;

	always_comb begin
		step = STEP_DIAG;
		for (int i = NSTEP - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				step = step_t'(i);
			end
		end
	end

	always_comb begin
		sx_w  = IDX_W'(cur_q.sx);
		sxy_w = IDX_W'(cur_q.sxy);
		diag_a = cur_q.even ? '0 : IDX_W'(1);
		diag_b = '0;
		case (step)
			STEP_XY_A, STEP_XY_B: diag_b = cur_q.even ? sx_w + IDX_W'(1) : sx_w;
			STEP_XZ_A, STEP_XZ_B: diag_b = cur_q.even ? sxy_w + IDX_W'(1) : sxy_w;
			STEP_YZ_A, STEP_YZ_B: begin
				diag_a = cur_q.even ? '0 : sx_w;
				diag_b = cur_q.even ? sx_w + sxy_w : sxy_w;
			end
			default: ;
		endcase
		off_r = '0;
		off_c = '0;
		case (step)
			STEP_DIAG: ;
			STEP_XN_A: off_c = '1;
			STEP_XN_B: off_r = '1;
			STEP_YN_A: off_c = IDX_W'(0) - sx_w;
			STEP_YN_B: off_r = IDX_W'(0) - sx_w;
			STEP_ZN_A: off_c = IDX_W'(0) - sxy_w;
			STEP_ZN_B: off_r = IDX_W'(0) - sxy_w;
			STEP_XY_A, STEP_XZ_A, STEP_YZ_A: begin
				off_r = diag_a;
				off_c = diag_b;
			end
			STEP_XY_B, STEP_XZ_B, STEP_YZ_B: begin
				off_r = diag_b;
				off_c = diag_a;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rem_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			rem_q  <= q_data.mask;
		end else if (emit) begin
			busy_q <= !last;
			rem_q  <= rem_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (ent.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_q  <= cur_q.inv ? '0 : cur_q.p + off_r;
			col_q  <= cur_q.inv ? '0 : cur_q.p + off_c;
			last_q <= last;
			inv_q  <= cur_q.inv;
		end
	end

	assign ent.valid         = ov_q;
	assign ent.row_index     = row_q;
	assign ent.col_index     = col_q;
	assign ent.last_entry    = last_q;
	assign ent.point_invalid = inv_q;

endmodule

`default_nettype wire

// File: design/mesh_stencil_pattern_generator.sv
// ============================================================================
// Mesh stencil pattern generator
// Produces the nonzero coordinates that one grid point adds to the incidence
// matrix of a box mesh, with optional tetrahedral face diagonals.
// ============================================================================
// Each accepted grid point yields between 1 and 13 matrix entries: the entry
// sequencer emits one coordinate pair per cycle while the output is not held
// by back-pressure, and it sets the throughput. A point outside the configured
// sizes yields a single entry flagged invalid. The front end registers each
// point in its s1 and s2 stages, and a four-deep queue lets it keep accepting
// points while the sequencer is still working through earlier ones. Sizes
// must be written through the configuration port only while no transaction
// is in flight; the user is bound to this, the block does not enforce it.
`default_nettype none

module mesh_stencil_pattern_generator #(
	parameter int MAX_DIM = msp_pkg::DEF_MAX_DIM
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [msp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [msp_pkg::CFG_DATA_W-1:0] cfg_data,
	msp_point_if.sink pt,
	msp_entry_if.source ent
);
	import msp_pkg::*;

	entry_t f_data;
	logic f_valid;
	logic f_ready;
	entry_t b_data;
	logic b_valid;
	logic b_ready;

	msp_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.pt(pt),
		.q_data(f_data),
		.q_valid(f_valid),
		.q_ready(f_ready)
	);

	msp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_data(f_data),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.pop_data(b_data),
		.pop_valid(b_valid),
		.pop_ready(b_ready)
	);

	msp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_data(b_data),
		.q_valid(b_valid),
		.q_ready(b_ready),
		.ent(ent)
	);

	a_invalid_alone: assert property (@(posedge clk) disable iff (!arst_n)
		ent.valid && ent.point_invalid |->
			ent.last_entry && ent.row_index == '0 && ent.col_index == '0)
		else $error("Invalid point result is not a lone zero entry.");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		ent.valid && ent.ready && !ent.last_entry |=> ent.valid)
		else $error("Entry sequence of a point has a gap.");

	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && f_ready |=> b_valid)
		else $error("Queue empty right after a push.");

endmodule

`default_nettype wire
